### design/dns_query_match_verdict_top_defines.svh
// Assertion macros shared by the design files
`ifndef DNS_QUERY_MATCH_VERDICT_TOP_DEFINES_SVH
`define DNS_QUERY_MATCH_VERDICT_TOP_DEFINES_SVH

// property checked on every clock edge out of reset
`define DQMV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define DQMV_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### design/dqmv_pkg.sv
package dqmv_pkg;

    localparam int MAX_PACKET_BYTES = 512;
    localparam int NAME_MAX_CHARS   = 32;
    localparam int NAME_REGS        = 4;
    localparam int CFG_INDEX_W      = 3;
    localparam int CFG_DATA_W       = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_NAME_CHARS_0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_CHARS_1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_CHARS_2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_CHARS_3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_LENGTH  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MISS_RCODE   = 3'd5;

    localparam logic [1:0] VERDICT_DROP      = 2'd0;
    localparam logic [1:0] VERDICT_ANSWER    = 2'd1;
    localparam logic [1:0] VERDICT_ERR_NOQ   = 2'd2;
    localparam logic [1:0] VERDICT_ERR_WITHQ = 2'd3;

    localparam logic [3:0] RCODE_OK       = 4'd0;
    localparam logic [3:0] RCODE_FORMAT   = 4'd1;
    localparam logic [3:0] RCODE_BAD_TYPE = 4'd3;
    localparam logic [3:0] RCODE_NOT_IMPL = 4'd4;
    localparam logic [3:0] RCODE_RESET    = 4'd3;

    typedef struct packed {
        logic [NAME_REGS-1:0][CFG_DATA_W-1:0] name_chars;
        logic [5:0]                           name_length;
        logic [3:0]                           miss_rcode;
    } name_cfg_t;

    typedef struct packed {
        logic [1:0] verdict;
        logic [3:0] reply_code;
        logic [8:0] question_length;
    } result_t;

endpackage

### design/dqmv_parse.sv
module dqmv_parse
    import dqmv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  name_cfg_t cfg,
    input  logic      in_valid,
    output logic      in_stall,
    input  logic [7:0] packet_byte,
    input  logic      last_byte,
    input  logic      q_full,
    output logic      res_valid,
    output result_t   res
);

`include "dns_query_match_verdict_top_defines.svh"

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LEN    = 3'd1;
    localparam logic [2:0] PH_LABEL  = 3'd2;
    localparam logic [2:0] PH_TAIL   = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [9:0] MAX_BYTES = 10'(MAX_PACKET_BYTES);

    typedef struct packed {
        logic       dead;
        logic [5:0] pos;
    } match_t;

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    function automatic logic [7:0] name_char(input logic [255:0] chars, input logic [4:0] i);
        return chars[{i, 3'b000} +: 8];
    endfunction

    function automatic match_t match_step(input match_t m, input logic is_len,
                                          input logic first, input logic [7:0] b,
                                          input logic [5:0] len, input logic [5:0] off,
                                          input logic [255:0] chars);
        match_t     r;
        logic [7:0] c;
        r = m;
        c = name_char(chars, off[4:0] + m.pos[4:0]);
        if (!m.dead)
        begin
            if (is_len)
            begin
                if (first)
                begin
                    if (b == 8'd0)
                        r.dead = 1'b1;
                end
                else if (b == 8'd0)
                begin
                    if (m.pos != len)
                        r.dead = 1'b1;
                end
                else if (m.pos < len && c == 8'h2E)
                    r.pos = m.pos + 6'd1;
                else
                    r.dead = 1'b1;
            end
            else if (m.pos < len && c == to_lower(b))
                r.pos = m.pos + 6'd1;
            else
                r.dead = 1'b1;
        end
        return r;
    endfunction

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       adv;
    logic       fire;

    // packet state
    logic [9:0]  bc_reg, bc_next;
    logic [1:0]  hv_reg, hv_next;
    logic [2:0]  ph_reg, ph_next;
    logic [7:0]  lbl_reg, lbl_next;
    match_t      plain_reg, plain_next;
    match_t      skip_reg, skip_next;
    logic        notwww_reg, notwww_next;
    logic [31:0] tc_reg, tc_next;
    logic [8:0]  qb_reg, qb_next;

    logic [255:0] chars;
    logic [5:0]   clamped;
    logic [5:0]   off;
    logic [5:0]   len;
    logic [8:0]   q;
    logic [7:0]   lb;
    logic [1:0]   hcode;
    logic [15:0]  qtype;
    logic [15:0]  qclass;
    logic         dead;
    result_t      res_c;

    assign adv      = !(s1_last_reg && q_full);
    assign in_stall = s1_valid_reg && !adv;
    assign fire     = s1_valid_reg && adv;

    assign chars   = cfg.name_chars;
    assign clamped = (cfg.name_length > 6'(NAME_MAX_CHARS)) ? 6'(NAME_MAX_CHARS)
                                                            : cfg.name_length;
    assign off     = (clamped >= 6'd4 && chars[31:0] == 32'h2E77_7777) ? 6'd4 : 6'd0;
    assign len     = clamped - off;

    always_comb
    begin
        bc_next     = bc_reg;
        hv_next     = hv_reg;
        ph_next     = ph_reg;
        lbl_next    = lbl_reg;
        plain_next  = plain_reg;
        skip_next   = skip_reg;
        notwww_next = notwww_reg;
        tc_next     = tc_reg;
        qb_next     = qb_reg;
        q           = 9'(bc_reg - 10'd12);
        lb          = to_lower(s1_byte_reg);
        hcode       = 2'd0;

        if (bc_reg < 10'd12)
        begin
            if (bc_reg == 10'd2)
            begin
                if (s1_byte_reg[7])
                    hcode = 2'd1;
                else if (s1_byte_reg[6:3] != 4'd0)
                    hcode = 2'd2;
            end
            else if (bc_reg == 10'd4)
            begin
                if (s1_byte_reg != 8'd0)
                    hcode = 2'd3;
            end
            else if (bc_reg == 10'd5)
            begin
                if (s1_byte_reg != 8'd1)
                    hcode = 2'd3;
            end
            else if (bc_reg >= 10'd6)
            begin
                if (s1_byte_reg != 8'd0)
                    hcode = 2'd3;
            end
            if (hv_reg == 2'd0)
                hv_next = hcode;
            if (bc_reg == 10'd11)
                ph_next = PH_LEN;
        end
        else if (bc_reg < MAX_BYTES && ph_reg != PH_DONE)
        begin
            qb_next = qb_reg + 9'd1;
            unique case (ph_reg)
                PH_LEN:
                begin
                    if (q == 9'd0 && s1_byte_reg != 8'd3)
                        notwww_next = 1'b1;
                    plain_next = match_step(plain_reg, 1'b1, q == 9'd0, s1_byte_reg,
                                            len, off, chars);
                    if (q >= 9'd4)
                        skip_next = match_step(skip_reg, 1'b1, q == 9'd4, s1_byte_reg,
                                               len, off, chars);
                    if (s1_byte_reg == 8'd0)
                    begin
                        ph_next  = PH_TAIL;
                        lbl_next = 8'd0;
                    end
                    else
                    begin
                        ph_next  = PH_LABEL;
                        lbl_next = s1_byte_reg;
                    end
                end
                PH_LABEL:
                begin
                    if (q >= 9'd1 && q <= 9'd3 && lb != 8'h77)
                        notwww_next = 1'b1;
                    plain_next = match_step(plain_reg, 1'b0, 1'b0, s1_byte_reg,
                                            len, off, chars);
                    if (q >= 9'd4)
                        skip_next = match_step(skip_reg, 1'b0, 1'b0, s1_byte_reg,
                                               len, off, chars);
                    lbl_next = lbl_reg - 8'd1;
                    if (lbl_next == 8'd0)
                        ph_next = PH_LEN;
                end
                default:
                begin
                    tc_next  = {tc_reg[23:0], s1_byte_reg};
                    lbl_next = lbl_reg + 8'd1;
                    if (lbl_next >= 8'd4)
                        ph_next = PH_DONE;
                end
            endcase
        end

        if (bc_reg <= MAX_BYTES)
            bc_next = bc_reg + 10'd1;
    end

    // verdict from the state after this byte
    always_comb
    begin
        qtype  = tc_next[31:16];
        qclass = tc_next[15:0];
        dead   = notwww_next ? plain_next.dead : skip_next.dead;
        res_c.verdict         = VERDICT_DROP;
        res_c.reply_code      = RCODE_OK;
        res_c.question_length = 9'd0;
        if (bc_next < 10'd12 || bc_next > MAX_BYTES || hv_next == 2'd1)
            res_c.verdict = VERDICT_DROP;
        else if (hv_next == 2'd2)
        begin
            res_c.verdict    = VERDICT_ERR_NOQ;
            res_c.reply_code = RCODE_NOT_IMPL;
        end
        else if (hv_next == 2'd3 || ph_next != PH_DONE)
        begin
            res_c.verdict    = VERDICT_ERR_NOQ;
            res_c.reply_code = RCODE_FORMAT;
        end
        else
        begin
            res_c.verdict         = VERDICT_ERR_WITHQ;
            res_c.question_length = qb_next;
            if ((qclass != 16'd1 && qclass != 16'd255) ||
                (qtype != 16'd1 && qtype != 16'd255))
                res_c.reply_code = RCODE_BAD_TYPE;
            else if (len == 6'd0)
                res_c.reply_code = cfg.miss_rcode;
            else if (len == 6'd1 && name_char(chars, off[4:0]) == 8'h2A)
                res_c.verdict = VERDICT_ANSWER;
            else if (dead)
                res_c.reply_code = cfg.miss_rcode;
            else
                res_c.verdict = VERDICT_ANSWER;
        end
    end

    assign res_valid = fire && s1_last_reg;
    assign res       = res_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            s1_valid_reg <= 1'b1;
        else if (fire)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= packet_byte;
            s1_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg     <= 10'd0;
            hv_reg     <= 2'd0;
            ph_reg     <= PH_HEADER;
            lbl_reg    <= 8'd0;
            plain_reg  <= '0;
            skip_reg   <= '0;
            notwww_reg <= 1'b0;
            tc_reg     <= 32'd0;
            qb_reg     <= 9'd0;
        end
        else if (fire)
        begin
            if (s1_last_reg)
            begin
                bc_reg     <= 10'd0;
                hv_reg     <= 2'd0;
                ph_reg     <= PH_HEADER;
                lbl_reg    <= 8'd0;
                plain_reg  <= '0;
                skip_reg   <= '0;
                notwww_reg <= 1'b0;
                tc_reg     <= 32'd0;
                qb_reg     <= 9'd0;
            end
            else
            begin
                bc_reg     <= bc_next;
                hv_reg     <= hv_next;
                ph_reg     <= ph_next;
                lbl_reg    <= lbl_next;
                plain_reg  <= plain_next;
                skip_reg   <= skip_next;
                notwww_reg <= notwww_next;
                tc_reg     <= tc_next;
                qb_reg     <= qb_next;
            end
        end
    end

    `DQMV_ASSERT(a_noq_len, res_valid && (res.verdict == VERDICT_DROP || res.verdict == VERDICT_ERR_NOQ) |-> res.question_length == 9'd0, "question length set without question")
    `DQMV_ASSERT(a_clear, res_valid |=> bc_reg == 10'd0 && ph_reg == PH_HEADER, "packet state not cleared after item")
    `DQMV_NEVER(a_bc_range, bc_reg > MAX_BYTES + 10'd1, "byte count beyond saturation")

endmodule

### design/dqmv_outq.sv
module dqmv_outq
    import dqmv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  result_t    push_data,
    output logic       full,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] verdict,
    output logic [3:0] reply_code,
    output logic [8:0] question_length
);

`include "dns_query_match_verdict_top_defines.svh"

    result_t    slot_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign full      = count_reg == 2'd2;
    assign out_valid = count_reg != 2'd0;
    assign pop       = out_valid && !out_stall;

    assign verdict         = slot_reg[rd_ptr_reg].verdict;
    assign reply_code      = slot_reg[rd_ptr_reg].reply_code;
    assign question_length = slot_reg[rd_ptr_reg].question_length;

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    `DQMV_NEVER(a_overflow, push && full, "item pushed into full result queue")
    `DQMV_NEVER(a_count, count_reg == 2'd3, "result queue count out of range")

endmodule

### design/dns_query_match_verdict_top.sv
// DNS request verdict block. Takes a request packet one byte per item (last_byte
// marks the final byte) and gives one verdict item per packet: drop, answer, or
// error with or without the question echoed, plus reply code and question
// length. A byte is taken every cycle unless in_stall is high; each byte passes
// an input register and combinational header/label/match logic, and a verdict is
// pushed into the result queue when its final byte leaves the input register. A
// two-entry result queue lets input keep flowing while a verdict waits; input
// stalls only when a final byte meets a full queue.
// Configuration (name characters, name length, miss reply code) must be written by
// the user between packets while the block is idle; the block does not enforce it.
module dns_query_match_verdict_top
    import dqmv_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             packet_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             verdict,
    output logic [3:0]             reply_code,
    output logic [8:0]             question_length
);

    name_cfg_t cfg_reg;
    logic      q_full;
    logic      res_valid;
    result_t   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.name_chars  <= '0;
            cfg_reg.name_length <= 6'd0;
            cfg_reg.miss_rcode  <= RCODE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_NAME_CHARS_0: cfg_reg.name_chars[0] <= cfg_data;
                REG_NAME_CHARS_1: cfg_reg.name_chars[1] <= cfg_data;
                REG_NAME_CHARS_2: cfg_reg.name_chars[2] <= cfg_data;
                REG_NAME_CHARS_3: cfg_reg.name_chars[3] <= cfg_data;
                REG_NAME_LENGTH:  cfg_reg.name_length   <= cfg_data[5:0];
                REG_MISS_RCODE:   cfg_reg.miss_rcode    <= cfg_data[3:0];
                default:          cfg_reg               <= cfg_reg;
            endcase
        end
    end

    dqmv_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .packet_byte (packet_byte),
        .last_byte   (last_byte),
        .q_full      (q_full),
        .res_valid   (res_valid),
        .res         (res)
    );

    dqmv_outq u_outq (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (res_valid),
        .push_data       (res),
        .full            (q_full),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .verdict         (verdict),
        .reply_code      (reply_code),
        .question_length (question_length)
    );

endmodule
